### sv/sorted_priority_queue_defines.svh
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_priority_queue: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_priority_queue: next-cycle check failed");

`endif

### sv/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] value;
    logic [7:0]         priority_req;
  } req_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic               head_valid;
    logic [4:0]         entry_count;
    status_e            status;
  } rsp_t;

  typedef struct packed {
    logic               used;
    logic [7:0]         prio;
    logic signed [31:0] value;
  } slot_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [7:0]         prio;
    logic signed [31:0] value;
  } ctrl_t;

endpackage

### sv/spq_cell.sv
// One slot of the sorted queue chain: compare, hold, insert or shift.
`timescale 1ns / 1ps
module spq_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::ctrl_t ctrl_i,
  input  spq_pkg::slot_t left_i,
  input  logic          left_keep_i,
  input  spq_pkg::slot_t right_i,
  output spq_pkg::slot_t slot_o,
  output logic          keep_o
);

  logic               used_q;
  logic [7:0]         prio_q;
  logic signed [31:0] value_q;
  spq_pkg::slot_t     slot_cur;
  spq_pkg::slot_t     slot_d;

  assign slot_cur = '{used: used_q, prio: prio_q, value: value_q};

  assign keep_o = used_q && (prio_q <= ctrl_i.prio);

  always_comb begin
    slot_d = slot_cur;
    if (ctrl_i.push) begin
      if (keep_o) begin
        slot_d = slot_cur;
      end else if (left_keep_i) begin
        slot_d.used  = 1'b1;
        slot_d.prio  = ctrl_i.prio;
        slot_d.value = ctrl_i.value;
      end else begin
        slot_d = left_i;
      end
    end else if (ctrl_i.pop) begin
      slot_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= slot_d.used;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q  <= slot_d.prio;
    value_q <= slot_d.value;
  end

  assign slot_o = slot_cur;

endmodule

### sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, count and result register.
`timescale 1ns / 1ps
// Usage
//   Command channel: drive req_i and raise start_i; the transaction is taken at
//   the rising edge where start_i is high and busy_o is low. busy_o stays low,
//   so one push or pop is taken every cycle.
//   Result channel: result_valid_o pulses for one cycle, in the cycle after the
//   accepting edge, with result_o describing the queue after that command:
//   head value (zero when empty), head valid, entry count and status.
//   Throughput is one command per cycle: every cell of the chain compares its
//   priority with the request in the same cycle and holds, takes the new
//   entry, or takes a neighbor's entry.
//   A push on a full queue and a pop on an empty queue leave the queue as it
//   was and report the matching status.
//   Equal priorities leave in arrival order.
//   The receiver cannot stall; results are shown for exactly one cycle.
//   Reset empties the queue at once; entry contents are not cleared.
`include "sorted_priority_queue_defines.svh"
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  spq_pkg::req_t req_i,
  output logic          result_valid_o,
  output spq_pkg::rsp_t result_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             res_valid_q;
  spq_pkg::status_e status_q, status_d;

  logic           accept;
  logic           full;
  logic           empty;
  logic           push_full;
  logic           pop_empty;
  spq_pkg::ctrl_t ctrl;

  spq_pkg::slot_t slots [QUEUE_DEPTH+1];
  logic           keeps [QUEUE_DEPTH];
  spq_pkg::slot_t left_edge;
  spq_pkg::slot_t right_edge;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty  = (cnt_q == '0);

  assign push_full = accept && (req_i.command == spq_pkg::CMD_PUSH) && full;
  assign pop_empty = accept && (req_i.command == spq_pkg::CMD_POP) && empty;

  assign ctrl.push  = accept && (req_i.command == spq_pkg::CMD_PUSH) && !full;
  assign ctrl.pop   = accept && (req_i.command == spq_pkg::CMD_POP) && !empty;
  assign ctrl.prio  = req_i.priority_req;
  assign ctrl.value = req_i.value;

  assign left_edge  = '{used: 1'b1, prio: '0, value: '0};
  assign right_edge = '{used: 1'b0, prio: '0, value: '0};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_i      ((i == 0) ? left_edge : slots[(i == 0) ? 0 : i-1]),
      .left_keep_i ((i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i-1]),
      .right_i     ((i == QUEUE_DEPTH-1) ? right_edge : slots[i+1]),
      .slot_o      (slots[i]),
      .keep_o      (keeps[i])
    );
  end
  assign slots[QUEUE_DEPTH] = right_edge;

  always_comb begin
    cnt_d    = cnt_q;
    status_d = spq_pkg::STATUS_OK;
    if (ctrl.push) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctrl.pop) begin
      cnt_d = cnt_q - 1'b1;
    end
    if (push_full) begin
      status_d = spq_pkg::STATUS_FULL;
    end else if (pop_empty) begin
      status_d = spq_pkg::STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      status_q    <= spq_pkg::STATUS_OK;
    end else begin
      cnt_q       <= cnt_d;
      res_valid_q <= accept;
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  assign result_valid_o         = res_valid_q;
  assign result_o.head_valid    = slots[0].used;
  assign result_o.head_value    = slots[0].used ? slots[0].value : '0;
  assign result_o.entry_count   = 5'(cnt_q);
  assign result_o.status        = status_q;

  `SPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(QUEUE_DEPTH))
  `SPQ_ASSERT_NOW(a_head_matches_cnt, 1'b1, slots[0].used == (cnt_q != '0))
  `SPQ_ASSERT_NEXT(a_result_follows, accept, res_valid_q)
  `SPQ_ASSERT_NEXT(a_full_push, push_full, status_q == spq_pkg::STATUS_FULL && $stable(cnt_q))

endmodule
